// File: sv/mso_pkg.sv
package mso_pkg;

    // Default configuration of the oscillator bank.
    localparam int CHANNELS_DEF        = 8;
    localparam int SINE_ADDR_BITS_DEF  = 10;

    // Width used to compare a channel number against the channel count.
    localparam int CH_EXT_W = 7;

    // Fixed-point constants of the quarter-wave table (Q1.30).
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam int          ENTRY_W     = 31;
    localparam int          TAYLOR_MAX  = 24;

    // Output scaling: multiply by 0x7fff, then drop 45 fraction bits.
    localparam int          AMP_W       = 16;
    localparam int          SAMPLE_W    = 16;
    localparam int          PROD_W      = ENTRY_W + AMP_W;
    localparam int          SCALE_SHIFT = 15;
    localparam int          SCALED_W    = PROD_W + SCALE_SHIFT;
    localparam int          DROP_BITS   = 45;
    localparam int          MAG_W       = 15;
    localparam logic [16:0] MAG_LIMIT   = 17'd32767;

    // Sideband that travels with a sample through the scaling stages.
    typedef struct packed {
        logic                       gen_en;
        logic                       neg;
        logic                       mix;
        logic signed [SAMPLE_W-1:0] prior;
        logic                       last;
    } t_side;

    // Unsigned long division by shift and subtract.
    // Only evaluated while the quarter-wave table is elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine of a Q30 angle by Taylor series, clamped to [0, 1.0].
    // Used only while the quarter-wave table is elaborated.
    function automatic logic [ENTRY_W-1:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        div;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k < TAYLOR_MAX; k++) begin
            if (term != 64'd0) begin
                div  = 64'((2 * k) * (2 * k + 1));
                term = udiv64((term * x2) >> 30, div);
                if (k[0]) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > signed'(ONE_Q30)) begin
            sum = signed'(ONE_Q30);
        end
        return ENTRY_W'(sum);
    endfunction

endpackage

// File: sv/mso_phase_ram.sv
module mso_phase_ram
    import mso_pkg::*;
#(
    parameter int DEPTH = CHANNELS_DEF,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    output logic [31:0]   o_rd_data
);

    logic [31:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_rd_data;
    logic             r_rd_vld;

    // Phase storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Written-since-reset flags; an unwritten entry reads as phase zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 32'd0;

endmodule

// File: sv/mso_sine_rom.sv
module mso_sine_rom
    import mso_pkg::*;
#(
    parameter int ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [ADDR_BITS:0] i_addr,
    output logic [ENTRY_W-1:0] o_entry
);

    localparam int QTAB_LEN = (1 << ADDR_BITS) + 1;

    typedef logic [ENTRY_W-1:0] t_rom [QTAB_LEN];

    // Entry i holds sin(pi/2 * i / 2^ADDR_BITS) in Q1.30.
    function automatic t_rom build_rom();
        t_rom        tab;
        logic [63:0] x;
        for (int i = 0; i < QTAB_LEN; i++) begin
            x      = (HALF_PI_Q30 * 64'(i)) >> ADDR_BITS;
            tab[i] = sine_q30(x);
        end
        return tab;
    endfunction

    localparam t_rom QUARTER_WAVE = build_rom();

    logic [ENTRY_W-1:0] r_entry;

    // Registered table read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= QUARTER_WAVE[i_addr];
        end
    end

    assign o_entry = r_entry;

endmodule

// File: sv/mso_amp_scale.sv
module mso_amp_scale
    import mso_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [AMP_W-1:0]           i_amp,
    input  t_side                      i_side,
    input  logic [ENTRY_W-1:0]         i_entry,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_overflow,
    output logic                       o_block_last
);

    logic [AMP_W-1:0]           r_amp;
    t_side                      r_side2;
    logic [PROD_W-1:0]          r_prod;
    t_side                      r_side3;
    logic [MAG_W-1:0]           r_mag;
    t_side                      r_side4;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_overflow;
    logic                       r_last;

    logic [PROD_W-1:0]          prod;
    logic [SCALED_W-1:0]        scaled;
    logic [16:0]                mag_wide;
    logic [MAG_W-1:0]           mag;
    logic signed [16:0]         gen;
    logic signed [16:0]         sum;
    logic signed [SAMPLE_W-1:0] n_sample;
    logic                       n_overflow;

    // Table entry times amplitude.
    assign prod = PROD_W'(i_entry) * PROD_W'(r_amp);

    // Times 0x7fff as a shift and subtract, drop the fraction, saturate.
    assign scaled   = {r_prod, {SCALE_SHIFT{1'b0}}} - SCALED_W'(r_prod);
    assign mag_wide = scaled[DROP_BITS +: 17];
    assign mag      = (mag_wide > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : mag_wide[MAG_W-1:0];

    // Apply the sign, then optionally mix into the prior sample with wrap.
    always_comb begin
        if (r_side4.gen_en) begin
            gen = r_side4.neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
        end else begin
            gen = 17'sd0;
        end
        sum = $signed({r_side4.prior[SAMPLE_W-1], r_side4.prior}) + gen;
        if (r_side4.mix) begin
            n_sample   = sum[SAMPLE_W-1:0];
            n_overflow = sum[16] != sum[15];
        end else begin
            n_sample   = gen[SAMPLE_W-1:0];
            n_overflow = 1'b0;
        end
    end

    // Stage registers, all advancing together.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amp      <= i_amp;
            r_side2    <= i_side;
            r_prod     <= prod;
            r_side3    <= r_side2;
            r_mag      <= mag;
            r_side4    <= r_side3;
            r_sample   <= n_sample;
            r_overflow <= n_overflow;
            r_last     <= r_side4.last;
        end
    end

    assign o_sample     = r_sample;
    assign o_overflow   = r_overflow;
    assign o_block_last = r_last;

endmodule

// File: sv/multichannel_sine_oscillator.sv
// Multichannel sine oscillator: one phase accumulator per channel, quarter-wave lookup.
// A result beat passes five register stages (stage one, table read, product,
// magnitude, output). Throughput: one beat per cycle unless the output stalls;
// a read-modify-write of the phase memory per beat, with forwarding when the
// same channel comes in consecutive beats.
// Reset clears all channel phases to zero at once and empties the pipeline.
module multichannel_sine_oscillator
    import mso_pkg::*;
#(
    parameter int CHANNELS             = CHANNELS_DEF,
    parameter int SINE_TABLE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_channel,
    input  logic [31:0]                i_phase_step,
    input  logic [AMP_W-1:0]           i_amplitude,
    input  logic                       i_mix,
    input  logic signed [SAMPLE_W-1:0] i_prior_sample,
    input  logic                       i_end_of_block,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_overflow,
    output logic                       o_block_last
);

    localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROM_AW = SINE_TABLE_ADDR_BITS + 1;
    localparam logic [ROM_AW-1:0] QUARTER = ROM_AW'(1) << SINE_TABLE_ADDR_BITS;

    logic                       adv;
    logic [CH_EXT_W-1:0]        ch_ext;
    logic                       in_range;
    logic [CH_AW-1:0]           rd_addr;
    logic [31:0]                ram_rd;
    logic [31:0]                cur_phase;
    logic [31:0]                nxt_phase;
    logic                       wr_en;
    logic [SINE_TABLE_ADDR_BITS-1:0] offset;
    logic [ROM_AW-1:0]          rom_addr;
    logic [ENTRY_W-1:0]         entry;
    t_side                      side;

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_v4;
    logic                       r_ov;
    logic                       r_fwd_hit;
    logic [31:0]                r_fwd_phase;
    logic                       r_s1_inrange;
    logic [CH_AW-1:0]           r_s1_addr;
    logic [31:0]                r_s1_step;
    logic [AMP_W-1:0]           r_s1_amp;
    logic                       r_s1_mix;
    logic signed [SAMPLE_W-1:0] r_s1_prior;
    logic                       r_s1_last;

    // The whole pipeline moves unless a finished beat is held at the output.
    assign adv     = !r_ov || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_ov;

    // Channel decode for the phase memory read.
    assign ch_ext   = CH_EXT_W'(i_channel);
    assign in_range = ch_ext < CH_EXT_W'(CHANNELS);
    assign rd_addr  = in_range ? ch_ext[CH_AW-1:0] : '0;

    // Phase of the stage-one beat, taken from the last write when it raced the read.
    assign cur_phase = r_fwd_hit ? r_fwd_phase : ram_rd;
    assign nxt_phase = cur_phase + r_s1_step;
    assign wr_en     = adv && r_v1 && r_s1_inrange;

    // Quadrant fold into the quarter-wave table address.
    assign offset   = cur_phase[29 -: SINE_TABLE_ADDR_BITS];
    assign rom_addr = cur_phase[30] ? (QUARTER - ROM_AW'(offset)) : ROM_AW'(offset);

    always_comb begin
        side.gen_en = r_s1_inrange && (r_s1_step != 32'd0);
        side.neg    = cur_phase[31];
        side.mix    = r_s1_mix;
        side.prior  = r_s1_prior;
        side.last   = r_s1_last;
    end

    // Beat valid flags and the forwarding flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_ov      <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (adv) begin
            r_v1      <= i_valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_ov      <= r_v4;
            r_fwd_hit <= wr_en && i_valid && in_range && (r_s1_addr == rd_addr);
        end
    end

    // Stage-one payload and the phase just written back.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_phase  <= nxt_phase;
            r_s1_inrange <= in_range;
            r_s1_addr    <= rd_addr;
            r_s1_step    <= i_phase_step;
            r_s1_amp     <= i_amplitude;
            r_s1_mix     <= i_mix;
            r_s1_prior   <= i_prior_sample;
            r_s1_last    <= i_end_of_block;
        end
    end

    mso_phase_ram #(
        .DEPTH (CHANNELS),
        .AW    (CH_AW)
    ) u_phase_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (nxt_phase),
        .o_rd_data (ram_rd)
    );

    mso_sine_rom #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_addr  (rom_addr),
        .o_entry (entry)
    );

    mso_amp_scale u_amp_scale (
        .i_clk        (i_clk),
        .i_en         (adv),
        .i_amp        (r_s1_amp),
        .i_side       (side),
        .i_entry      (entry),
        .o_sample     (o_sample),
        .o_overflow   (o_overflow),
        .o_block_last (o_block_last)
    );

endmodule

// File: sv/mso_checker.sv
module mso_checker
    import mso_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [SAMPLE_W-1:0] o_sample,
    input logic                       o_overflow,
    input logic                       o_block_last
);

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // Input is held off only while a result beat waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not match output backpressure");

    // A stalled result beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample) && $stable(o_overflow)
            && $stable(o_block_last))
        else $error("stalled result beat changed");

    // No input beat is taken while the output is blocked.
    a_no_take_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && i_valid |-> o_stall)
        else $error("input beat taken while output blocked");

endmodule

bind multichannel_sine_oscillator mso_checker u_mso_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sample     (o_sample),
    .o_overflow   (o_overflow),
    .o_block_last (o_block_last)
);
